FILE: hw/rtl/kbps_pkg.sv
package kbps_pkg;

  localparam int unsigned CordicIters = 16;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [14:0] SteerLimit = 15'sd10923;
  localparam logic [15:0] WbMin = 16'd256;
  localparam logic [26:0] AngPerRadTenth = 27'd68356528;
  localparam logic [25:0] PosDiv = 26'd41943040;
  localparam logic [15:0] WheelBaseReset = 16'd1536;

  typedef enum logic [1:0] {
    CfgWheelBase    = 2'd0,
    CfgStartX       = 2'd1,
    CfgStartY       = 2'd2,
    CfgStartHeading = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StRotH,
    StRotS,
    StDivX,
    StDivY,
    StTanPrep,
    StDivT,
    StMulA,
    StMulB,
    StDivH,
    StDone
  } state_e;

  function automatic logic signed [33:0] atan_entry(input logic [3:0] i);
    logic signed [33:0] r;
    unique case (i)
      4'd0:  r = 34'sd536870912;
      4'd1:  r = 34'sd316933406;
      4'd2:  r = 34'sd167458907;
      4'd3:  r = 34'sd85004756;
      4'd4:  r = 34'sd42667331;
      4'd5:  r = 34'sd21354465;
      4'd6:  r = 34'sd10679838;
      4'd7:  r = 34'sd5340245;
      4'd8:  r = 34'sd2670163;
      4'd9:  r = 34'sd1335087;
      4'd10: r = 34'sd667544;
      4'd11: r = 34'sd333772;
      4'd12: r = 34'sd166886;
      4'd13: r = 34'sd83443;
      4'd14: r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/kbps_divider.sv
// Restoring divider on magnitudes, one quotient bit per cycle, round half away.
module kbps_divider #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      // preload numerator plus half the divisor for rounding
      quot_d = num_i + NumW'(den_i >> 1);
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

FILE: hw/rtl/kinematic_bicycle_pose_step_core.sv
// Reload: the start pose is in the output register in the cycle after the command is taken.
// Advance: two 16-step CORDIC rotations (heading, then steer), then four bit-serial 64-bit
// divisions (x step, y step, tangent, heading change), with a setup state before the tangent
// division and two shift-add multiplies before the last one.
// Flow: one transaction at a time; the next is taken the cycle after the result is accepted.
// Reset (rst_ni low, asynchronous): pose and start registers clear, wheel base 6.0 m.
module kinematic_bicycle_pose_step_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // speed[15:0], steer_angle[30:16], zero pad
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pos_x_out, pos_y_out, heading_out
  output logic        m_axis_tuser,   // saturated
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  // config registers
  logic [15:0]        wb_q;
  logic signed [31:0] start_x_q, start_y_q;
  logic [31:0]        start_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q      <= kbps_pkg::WheelBaseReset;
      start_x_q <= '0;
      start_y_q <= '0;
      start_h_q <= '0;
    end else if (cfg_we_i) begin
      unique case (kbps_pkg::cfg_idx_e'(cfg_idx_i))
        kbps_pkg::CfgWheelBase:    wb_q <= cfg_wdata_i[15:0];
        kbps_pkg::CfgStartX:       start_x_q <= cfg_wdata_i;
        kbps_pkg::CfgStartY:       start_y_q <= cfg_wdata_i;
        kbps_pkg::CfgStartHeading: start_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  kbps_pkg::state_e state_q, state_d;

  logic signed [31:0] pos_x_q, pos_y_q;
  logic [31:0]        head_q;
  logic               sat_q;
  logic signed [15:0] speed_q;
  logic signed [14:0] steer_q;

  // CORDIC datapath, one iteration per cycle
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [3:0]         it_q;
  logic signed [33:0] hc_q, hs_q;

  // shift-add multiplier (serial over the multiplier bits)
  logic [63:0] macc_q;
  logic [63:0] mcand_q;
  logic [31:0] mplier_q;
  logic [5:0]  mcnt_q;
  logic        neg_q;

  // divider
  logic        dv_start;
  logic [63:0] dv_num;
  logic [47:0] dv_den;
  logic        dv_busy;
  logic [63:0] dv_quot;
  logic        dv_wait_q;

  kbps_divider #(.NumW(64), .DenW(48)) u_div (
    .clk_i, .rst_ni,
    .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .busy_o(dv_busy), .quot_o(dv_quot)
  );

  logic signed [15:0] speed_in;
  logic signed [14:0] steer_in;
  assign speed_in = s_axis_tdata[15:0];
  assign steer_in = s_axis_tdata[30:16];

  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  logic phase_done;
  logic signed [63:0] quot_s;
  assign quot_s = neg_q ? -$signed(dv_quot) : $signed(dv_quot);
  assign phase_done = dv_wait_q && !dv_busy && !dv_start;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kbps_pkg::StIdle:
        if (in_fire) state_d = s_axis_tuser ? kbps_pkg::StDone : kbps_pkg::StRotH;
      kbps_pkg::StRotH: if (it_q == 4'd15) state_d = kbps_pkg::StRotS;
      kbps_pkg::StRotS: if (it_q == 4'd15) state_d = kbps_pkg::StDivX;
      kbps_pkg::StDivX: if (phase_done) state_d = kbps_pkg::StDivY;
      kbps_pkg::StDivY: if (phase_done) state_d = kbps_pkg::StTanPrep;
      kbps_pkg::StTanPrep: state_d = kbps_pkg::StDivT;
      kbps_pkg::StDivT: if (phase_done) state_d = kbps_pkg::StMulA;
      kbps_pkg::StMulA: if (mcnt_q == 6'd0) state_d = kbps_pkg::StMulB;
      kbps_pkg::StMulB: if (mcnt_q == 6'd0) state_d = kbps_pkg::StDivH;
      kbps_pkg::StDivH: if (phase_done) state_d = kbps_pkg::StDone;
      kbps_pkg::StDone: if (out_fire) state_d = kbps_pkg::StIdle;
      default: state_d = kbps_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == kbps_pkg::StIdle);
    m_axis_tvalid = (state_q == kbps_pkg::StDone);
  end

  assign m_axis_tdata = {head_q, pos_y_q, pos_x_q};
  assign m_axis_tuser = sat_q;

  // Divider launch: magnitude of numerator, sign kept aside.
  logic signed [63:0] num_s;
  logic [63:0]        num_mag;
  logic               num_neg;
  logic [15:0]        wb_eff;
  always_comb begin
    dv_start = 1'b0;
    num_s    = '0;
    dv_den   = 48'(kbps_pkg::PosDiv);
    wb_eff   = (wb_q < kbps_pkg::WbMin) ? kbps_pkg::WbMin : wb_q;
    unique case (state_q)
      kbps_pkg::StDivX: num_s = $signed(macc_q);
      kbps_pkg::StDivY: num_s = $signed(macc_q);
      kbps_pkg::StDivT: begin
        num_s  = 64'(cy_q) <<< 16;
        dv_den = 48'($unsigned(cx_q));
      end
      kbps_pkg::StDivH: begin
        num_s  = $signed(macc_q);
        dv_den = {16'd0, wb_eff, 16'd0};
      end
      default: ;
    endcase
    num_neg = num_s[63];
    num_mag = num_neg ? 64'(-num_s) : num_s;
    dv_num  = num_mag;
    if (!dv_wait_q && (state_q == kbps_pkg::StDivX || state_q == kbps_pkg::StDivY ||
                       state_q == kbps_pkg::StDivT || state_q == kbps_pkg::StDivH))
      dv_start = 1'b1;
  end

  // saturating add of a step to a position
  function automatic logic [32:0] sat_add(input logic signed [31:0] p,
                                          input logic signed [63:0] d);
    logic signed [64:0] s;
    logic [32:0] r;
    s = 65'(p) + 65'(d);
    if (s > 65'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (s < -65'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, s[31:0]};
    return r;
  endfunction

  logic [32:0] sx_res, sy_res;
  assign sx_res = sat_add(pos_x_q, quot_s);
  assign sy_res = sat_add(pos_y_q, quot_s);

  // speed times sin (for x) or cos (for y), full 50-bit product
  logic signed [49:0] sp_prod;
  assign sp_prod = speed_q * ((state_q == kbps_pkg::StDivX) ? hc_q : hs_q);

  logic signed [14:0] steer_cl;
  assign steer_cl = (steer_q > kbps_pkg::SteerLimit) ? kbps_pkg::SteerLimit :
                    (steer_q < -kbps_pkg::SteerLimit) ? -kbps_pkg::SteerLimit : steer_q;

  // angle still to rotate: heading or steer at the first step, else the residue
  logic signed [33:0] rot_z;
  assign rot_z = (it_q == 4'd0 && state_q == kbps_pkg::StRotH) ?
                 $signed({4'd0, head_q[29:0]}) :
                 (it_q == 4'd0) ? $signed(34'(steer_cl) <<< 16) : cz_q;

  logic signed [33:0] cdx, cdy;
  assign cdx = cy_q >>> it_q;
  assign cdy = cx_q >>> it_q;

  logic signed [33:0] rot_c, rot_s;
  always_comb begin
    unique case (head_q[31:30])
      2'd0: begin rot_s = cy_q;  rot_c = cx_q;  end
      2'd1: begin rot_s = cx_q;  rot_c = -cy_q; end
      2'd2: begin rot_s = -cy_q; rot_c = -cx_q; end
      default: begin rot_s = -cx_q; rot_c = cy_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kbps_pkg::StIdle;
      dv_wait_q <= 1'b0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      head_q    <= '0;
      sat_q     <= 1'b0;
      it_q      <= '0;
      mcnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (dv_start) dv_wait_q <= 1'b1;
      else if (phase_done) dv_wait_q <= 1'b0;
      if (dv_start) neg_q <= num_neg;
      if (state_q != state_d) it_q <= '0;
      else it_q <= it_q + 1'b1;
      unique case (state_q)
        kbps_pkg::StIdle: if (in_fire) begin
          speed_q <= speed_in;
          steer_q <= steer_in;
          sat_q   <= 1'b0;
          if (s_axis_tuser) begin
            pos_x_q <= start_x_q;
            pos_y_q <= start_y_q;
            head_q  <= start_h_q;
          end
          cx_q <= kbps_pkg::CordicGain;
          cy_q <= '0;
          cz_q <= '0;
        end
        kbps_pkg::StRotH, kbps_pkg::StRotS: begin
          if (!rot_z[33]) begin
            cx_q <= ((it_q == 4'd0) ? kbps_pkg::CordicGain : cx_q) -
                    ((it_q == 4'd0) ? 34'sd0 : cdx);
            cy_q <= ((it_q == 4'd0) ? 34'sd0 : cy_q) +
                    ((it_q == 4'd0) ? kbps_pkg::CordicGain : cdy);
            cz_q <= rot_z - kbps_pkg::atan_entry(it_q);
          end else begin
            cx_q <= ((it_q == 4'd0) ? kbps_pkg::CordicGain : cx_q) +
                    ((it_q == 4'd0) ? 34'sd0 : cdx);
            cy_q <= ((it_q == 4'd0) ? 34'sd0 : cy_q) -
                    ((it_q == 4'd0) ? kbps_pkg::CordicGain : cdy);
            cz_q <= rot_z + kbps_pkg::atan_entry(it_q);
          end
          if (state_q == kbps_pkg::StRotS && it_q == 4'd15) begin
            // speed*sin(heading) for x
            macc_q <= 64'(sp_prod);
          end
          if (state_q == kbps_pkg::StRotS && it_q == 4'd0) begin
            hc_q <= rot_c;
            hs_q <= rot_s;
          end
        end
        kbps_pkg::StDivX: if (phase_done) begin
          pos_x_q <= sx_res[31:0];
          sat_q   <= sat_q | sx_res[32];
          macc_q  <= 64'(sp_prod);
        end
        kbps_pkg::StDivY: if (phase_done) begin
          pos_y_q <= sy_res[31:0];
          sat_q   <= sat_q | sy_res[32];
        end
        kbps_pkg::StDivT: if (phase_done) begin
          // speed * tan, serial over speed bits
          macc_q  <= '0;
          mcand_q <= quot_s;
          mplier_q <= 32'($signed(speed_q));
          mcnt_q  <= 6'd32;
        end
        kbps_pkg::StMulA: begin
          if (mcnt_q != 6'd0) begin
            if (mplier_q[0]) macc_q <= (mcnt_q == 6'd1) ? macc_q - mcand_q : macc_q + mcand_q;
            mcand_q  <= mcand_q << 1;
            mplier_q <= mplier_q >> 1;
            mcnt_q   <= mcnt_q - 1'b1;
          end else begin
            mcand_q  <= macc_q;
            mplier_q <= 32'(kbps_pkg::AngPerRadTenth);
            macc_q   <= '0;
            mcnt_q   <= 6'd32;
          end
        end
        kbps_pkg::StMulB: if (mcnt_q != 6'd0) begin
          if (mplier_q[0]) macc_q <= macc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          mcnt_q   <= mcnt_q - 1'b1;
        end
        kbps_pkg::StDivH: if (phase_done) head_q <= head_q - quot_s[31:0];
        default: ;
      endcase
    end
  end

  // The steer rotation reuses the CORDIC registers; heading results are
  // taken while they are still in cx/cy at the first cycle of StRotS.
  // Tangent numerator is ss*2^16, denominator sc (always positive for |steer|<=60 deg).

  property p_ready_only_idle;
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !s_axis_tready;
  endproperty
  assert property (p_ready_only_idle) else $error("input taken while result pending");

  property p_div_idle_out;
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !dv_busy;
  endproperty
  assert property (p_div_idle_out) else $error("divider busy at result");

  property p_result_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata);
  endproperty
  assert property (p_result_holds) else $error("result changed while stalled");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IdlePct = 36;
  localparam int unsigned StallLimit = 20000;
  localparam longint PosScale = 41943040;
  localparam longint AngScale = 68356528;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic        saturated;
  } pose_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // speed[15:0], steer_angle[30:16], zero pad
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;   // pos_x_out[31:0], pos_y_out[63:32], heading_out[95:64]
  logic        m_axis_tuser;   // saturated
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  kinematic_bicycle_pose_step_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // Shadow copy of the block: pose state and the four registers.
  logic [15:0]        wb_reg;
  logic signed [31:0] start_x_reg, start_y_reg;
  logic [31:0]        start_hd_reg;
  logic signed [31:0] pose_x, pose_y;
  logic [31:0]        pose_hd;

  pose_t  pose_q[$];
  int     mismatches = 0;
  bit     no_idle;
  int     stall_cnt = 0;

  longint atan_lut[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                           21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                           333772, 166886, 83443, 41722, 20861};

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Round to nearest, ties away from zero.
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    if (den < 1) den = 1;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Q2.30 cos/sin of a binary angle with |z| <= 2^30.
  function automatic void cordic(longint z, output longint c, output longint s);
    longint x, y, tx;
    x = longint'(kbps_pkg::CordicGain);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      tx = x;
      if (z >= 0) begin
        x = x - (y >>> i);
        y = y + (tx >>> i);
        z = z - atan_lut[i];
      end else begin
        x = x + (y >>> i);
        y = y - (tx >>> i);
        z = z + atan_lut[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint clip32(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Advance or reload the shadow pose and return the expected result.
  function automatic pose_t integrate_pose(bit reload, logic [15:0] spd_raw,
                                           logic [14:0] str_raw);
    pose_t  r;
    bit     hit;
    longint spd, str, rc, rs, hc, hs, sc, ss, tq, wb, dth;
    hit = 1'b0;
    spd = longint'(signed'(spd_raw));
    str = longint'(signed'(str_raw));
    if (reload) begin
      pose_x  = start_x_reg;
      pose_y  = start_y_reg;
      pose_hd = start_hd_reg;
    end else begin
      cordic(longint'({2'b00, pose_hd[29:0]}), rc, rs);
      case (pose_hd[31:30])
        2'd0: begin hs = rs;  hc = rc;  end
        2'd1: begin hs = rc;  hc = -rs; end
        2'd2: begin hs = -rs; hc = -rc; end
        default: begin hs = -rc; hc = rs; end
      endcase
      pose_x = 32'(clip32(longint'(pose_x) + round_div(spd * hs, PosScale), hit));
      pose_y = 32'(clip32(longint'(pose_y) + round_div(spd * hc, PosScale), hit));
      // Clamp steer to +-60 degrees.
      if (str > longint'(kbps_pkg::SteerLimit)) str = longint'(kbps_pkg::SteerLimit);
      if (str < -longint'(kbps_pkg::SteerLimit)) str = -longint'(kbps_pkg::SteerLimit);
      cordic(str * 65536, sc, ss);
      tq = round_div(ss * 65536, sc);
      wb = longint'(wb_reg);
      if (wb < longint'(kbps_pkg::WbMin)) wb = longint'(kbps_pkg::WbMin);
      dth = round_div(spd * tq * AngScale, wb * 65536);
      pose_hd = pose_hd - dth[31:0];
    end
    r.pos_x = pose_x;
    r.pos_y = pose_y;
    r.heading = pose_hd;
    r.saturated = hit;
    return r;
  endfunction

  // Send one transaction; insert random gaps first, leave tvalid high after.
  task automatic send_item(bit cmd, logic [15:0] spd, logic [14:0] str);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, str, spd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pose_q.push_back(integrate_pose(cmd, spd, str));
  endtask

  // Drain outstanding results, then write a register while the block is idle.
  task automatic write_reg(kbps_pkg::cfg_idx_e idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      kbps_pkg::CfgWheelBase:  wb_reg = val[15:0];
      kbps_pkg::CfgStartX:     start_x_reg = val;
      kbps_pkg::CfgStartY:     start_y_reg = val;
      default:                 start_hd_reg = val;
    endcase
  endtask

  task automatic load_pose(logic [31:0] x, logic [31:0] y, logic [31:0] hd);
    write_reg(kbps_pkg::CfgStartX, x);
    write_reg(kbps_pkg::CfgStartY, y);
    write_reg(kbps_pkg::CfgStartHeading, hd);
    send_item(1'b1, 16'($urandom), 15'($urandom));
  endtask

  // Straight-line and turning steps from the reset pose and wheel base.
  task automatic test_reset_pose();
    send_item(1'b0, 16'sd256, 15'sd0);
    send_item(1'b0, 16'h7FFF, 15'sd1000);
    send_item(1'b0, 16'h8000, -15'sd1000);
    send_item(1'b0, 16'sd0, 15'sd10923);
  endtask

  // Steer at the clamp limits and beyond them, both signs.
  task automatic test_steer_clamp();
    send_item(1'b0, 16'sd512, 15'sd10923);
    send_item(1'b0, 16'sd512, -15'sd10923);
    send_item(1'b0, 16'sd512, 15'h3FFF);
    send_item(1'b0, 16'sd512, 15'h4000);
    send_item(1'b0, -16'sd512, 15'sd12000);
  endtask

  // Wheel base below the floor counts as one metre; also the top value.
  task automatic test_wheel_base();
    logic [15:0] wbs[4] = '{16'd0, 16'd255, 16'd256, 16'hFFFF};
    foreach (wbs[i]) begin
      write_reg(kbps_pkg::CfgWheelBase, {16'd0, wbs[i]});
      send_item(1'b0, 16'h7FFF, 15'sd10923);
    end
    write_reg(kbps_pkg::CfgWheelBase, 32'd1536);
  endtask

  // Reload with headings in quadrants 1, 2 and 3; steps clip x at both int32 limits and y at the upper one.
  task automatic test_reload_and_clip();
    load_pose(32'h7FFF_0000, 32'h8000_0000, 32'h4000_0000);
    send_item(1'b0, 16'h7FFF, 15'sd0);
    send_item(1'b0, 16'h7FFF, 15'sd0);
    load_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000);
    send_item(1'b0, 16'h7FFF, 15'sd0);
    load_pose(32'h1234_5678, 32'hFEDC_BA98, 32'h8000_0000);
    send_item(1'b0, 16'h8000, 15'sd0);
    load_pose(32'h0, 32'h7FFF_F000, 32'hFFFF_FFFF);
    send_item(1'b0, 16'h7FFF, -15'sd5000);
  endtask

  task automatic test_random_drive(int n_items);
    logic [31:0] extremes[3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    for (int i = 0; i < n_items; i++) begin
      no_idle = (i >= 300 && i < 420);
      if (i % 100 == 50) begin
        write_reg(kbps_pkg::CfgWheelBase, (i % 200 == 50) ? $urandom_range(0, 65535)
                                                          : $urandom_range(256, 4096));
        write_reg(kbps_pkg::CfgStartX, ($urandom_range(3) == 0) ?
                                       extremes[$urandom_range(2)] : $urandom);
        write_reg(kbps_pkg::CfgStartY, ($urandom_range(3) == 0) ?
                                       extremes[$urandom_range(2)] : $urandom);
        write_reg(kbps_pkg::CfgStartHeading, $urandom);
      end
      send_item($urandom_range(15) == 0, 16'($urandom), 15'($urandom));
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, compare each transaction with the oldest prediction.
  always @(posedge clk_i) begin
    pose_t exp_r, got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
        if (pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = pose_q.pop_front();
          if (got.pos_x !== exp_r.pos_x || got.pos_y !== exp_r.pos_y ||
              got.heading !== exp_r.heading || got.saturated !== exp_r.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch x %h/%h y %h/%h hd %h/%h sat %b/%b (exp/got)",
                       exp_r.pos_x, got.pos_x, exp_r.pos_y, got.pos_y,
                       exp_r.heading, got.heading, exp_r.saturated, got.saturated);
          end
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = kbps_pkg::CfgWheelBase;
    cfg_wdata_i   = '0;
    no_idle       = 1'b0;
    wb_reg        = kbps_pkg::WheelBaseReset;
    start_x_reg   = '0;
    start_y_reg   = '0;
    start_hd_reg  = '0;
    pose_x        = '0;
    pose_y        = '0;
    pose_hd       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_pose();
    test_steer_clamp();
    test_wheel_base();
    test_reload_and_clip();
    test_random_drive(850);

    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
